// ----- hw/rtl/i2p_pkg.sv -----
// Shared types, constants and character helpers for the infix-to-postfix converter.
`timescale 1ns / 1ps
`default_nettype none

package i2p_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNMATCHED = 2'd2;

  typedef struct packed {
    logic [7:0] char_in;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic       expr_end;
    logic [1:0] error_code;
  } out_item_t;

  // Stack command and status between the sequencer and the stack.
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic [7:0] top;
  } stk_sts_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
    return p;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/infix_to_postfix_converter.sv -----
// Top level: shunting-yard sequencer, result staging and output register.
//
//   Channel | Ports                             | Direction | Payload
//   --------+-----------------------------------+-----------+------------------------------
//   input   | in_valid, in_ready, in_data       | in        | char_in, is_last
//   result  | out_valid, out_ready, out_data    | out       | char_out, char_valid,
//           |                                   |           | expr_end, error_code
//
// Steps: a letter or digit passes IDLE, FIN; '(' IDLE, PUSH, FIN; ')' IDLE, CLOSE, FIN;
// an operator IDLE, POP, PUSH, FIN. After a last character, FLUSH pops every entry left
// (up to STACK_DEPTH) before FIN. Every pop and the precedence compare go through the one
// stack port. Reset: rst_n clears the sequencer, stack fill count and valid flags; the stack
// contents are not cleared. Stalls: a step that stages a result holds while pend and out_r
// are full and out_ready is low; in_ready stays low until the item's last result is queued.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire i2p_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output i2p_pkg::out_item_t     out_data
);
  import i2p_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLOSE = 6'b000010,
    S_POP   = 6'b000100,
    S_PUSH  = 6'b001000,
    S_FLUSH = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic [7:0] c_r;
  logic       last_r;
  logic [1:0] prec_r;

  // One result is staged in pend so that expr_end can be set on the final one.
  logic       pend_vld_r;
  out_item_t  pend_r;
  logic       out_vld_r;
  out_item_t  out_r;

  stk_ctl_t   stk_ctl;
  stk_sts_t   stk_sts;

  logic       can_shift;
  logic       produce_ok;
  logic       produce;
  logic       fin_move;
  logic       fin_bare;
  logic       accept;
  out_item_t  new_res;
  state_t     after_op;

  i2p_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (stk_ctl),
    .push_data (c_r),
    .sts       (stk_sts)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_valid  = out_vld_r;
  assign out_data   = out_r;
  assign can_shift  = !out_vld_r || out_ready;
  assign produce_ok = !pend_vld_r || can_shift;
  assign after_op   = last_r ? S_FLUSH : S_FIN;

  always_comb begin
    state_nxt = state_r;
    stk_ctl   = '0;
    produce   = 1'b0;
    fin_move  = 1'b0;
    fin_bare  = 1'b0;
    new_res   = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (is_alnum(in_data.char_in)) begin
            // Literal goes straight to staging; pend is always empty here.
            new_res.char_out   = in_data.char_in;
            new_res.char_valid = 1'b1;
            produce            = 1'b1;
            state_nxt          = in_data.is_last ? S_FLUSH : S_FIN;
          end else if (in_data.char_in == CH_LPAREN) begin
            state_nxt = S_PUSH;
          end else if (in_data.char_in == CH_RPAREN) begin
            state_nxt = S_CLOSE;
          end else begin
            state_nxt = S_POP;
          end
        end
      end
      S_CLOSE: begin
        if (stk_sts.empty) begin
          new_res.error_code = ERR_UNMATCHED;
          if (produce_ok) begin
            produce   = 1'b1;
            state_nxt = after_op;
          end
        end else if (stk_sts.top == CH_LPAREN) begin
          // Drop the matching open parenthesis.
          stk_ctl.pop = 1'b1;
          state_nxt   = after_op;
        end else begin
          new_res.char_out   = stk_sts.top;
          new_res.char_valid = 1'b1;
          if (produce_ok) begin
            produce     = 1'b1;
            stk_ctl.pop = 1'b1;
          end
        end
      end
      S_POP: begin
        if (!stk_sts.empty && (prec_of(stk_sts.top) >= prec_r)) begin
          new_res.char_out   = stk_sts.top;
          new_res.char_valid = 1'b1;
          if (produce_ok) begin
            produce     = 1'b1;
            stk_ctl.pop = 1'b1;
          end
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (stk_sts.full) begin
          new_res.error_code = ERR_OVERFLOW;
          if (produce_ok) begin
            produce   = 1'b1;
            state_nxt = after_op;
          end
        end else begin
          stk_ctl.push = 1'b1;
          state_nxt    = after_op;
        end
      end
      S_FLUSH: begin
        if (!stk_sts.empty) begin
          new_res.char_out   = stk_sts.top;
          new_res.char_valid = 1'b1;
          if (produce_ok) begin
            produce     = 1'b1;
            stk_ctl.pop = 1'b1;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (pend_vld_r) begin
          if (can_shift) begin
            fin_move  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (last_r) begin
          if (can_shift) begin
            fin_bare  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (produce) begin
        pend_vld_r <= 1'b1;
      end else if (fin_move) begin
        pend_vld_r <= 1'b0;
      end
      if ((produce && pend_vld_r) || fin_move || fin_bare) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      c_r    <= in_data.char_in;
      last_r <= in_data.is_last;
      prec_r <= prec_of(in_data.char_in);
    end
    if (produce) begin
      pend_r <= new_res;
    end
    if (produce && pend_vld_r) begin
      out_r          <= pend_r;
      out_r.expr_end <= 1'b0;
    end else if (fin_move) begin
      out_r          <= pend_r;
      out_r.expr_end <= last_r;
    end else if (fin_bare) begin
      out_r          <= '0;
      out_r.expr_end <= 1'b1;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    stk_ctl.push |-> !stk_sts.full)
    else $error("push issued on a full stack");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    stk_ctl.pop |-> !stk_sts.empty)
    else $error("pop issued on an empty stack");

  a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(stk_ctl.push && stk_ctl.pop))
    else $error("push and pop in the same cycle");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_vld_r)
    else $error("staged result left over between items");

  a_err_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_r.char_valid && (out_r.error_code != ERR_NONE)))
    else $error("error result carries a character");

endmodule

`default_nettype wire

// ----- hw/rtl/i2p_stack.sv -----
// Operator stack: register file with push, pop and a registered fill count.
`timescale 1ns / 1ps
`default_nettype none

module i2p_stack #(
  parameter int DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire i2p_pkg::stk_ctl_t ctl,
  input  wire logic [7:0]        push_data,
  output i2p_pkg::stk_sts_t      sts
);
  import i2p_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  logic [7:0]    stack_r [DEPTH];
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [CW-1:0] top_cnt;
  logic [AW-1:0] top_idx;
  logic [AW-1:0] wr_idx;

  assign top_cnt = count_r - CW'(1);
  assign top_idx = top_cnt[AW-1:0];
  assign wr_idx  = count_r[AW-1:0];

  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == CW'(DEPTH));
  assign sts.top   = sts.empty ? 8'h00 : stack_r[top_idx];

  always_comb begin
    count_nxt = count_r;
    if (ctl.push && !sts.full) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.pop && !sts.empty) begin
      count_nxt = top_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !sts.full) begin
      stack_r[wr_idx] <= push_data;
    end
  end

endmodule

`default_nettype wire
